// ----- sv/stt_pkg.sv -----
// shared types, constants and the frequency-to-channel table of the station table
package stt_pkg;

  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned FREQ_W    = 16;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned FRAMES_W  = 24;
  localparam int unsigned CHAN_W    = 8;
  localparam int unsigned RIDX_W    = 5;
  localparam int unsigned CNT_OUT_W = 6;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned CFG_DAT_W = 8;

  localparam logic [CNT_OUT_W-1:0] CNT_OUT_MAX   = 6'd63;
  localparam logic [5:0]           ENTRIES_RESET = 6'd32;
  localparam logic                 AGING_RESET   = 1'b1;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AGING_ENABLE   = 4'd1;

  // request kinds
  localparam logic REQ_OBSERVE = 1'b0;
  localparam logic REQ_READ    = 1'b1;

  typedef enum logic [1:0] {
    ST_UPDATED  = 2'd0,
    ST_INSERTED = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_READ     = 2'd3
  } status_e;

  // aging tiers
  localparam logic [TIME_W-1:0]   AGE_KEEP     = 32'd5;
  localparam logic [TIME_W-1:0]   AGE_TIER1    = 32'd30;
  localparam logic [TIME_W-1:0]   AGE_TIER2    = 32'd60;
  localparam logic [TIME_W-1:0]   AGE_TIER3    = 32'd180;
  localparam logic [FRAMES_W-1:0] FRAMES_TIER0 = 24'd5;
  localparam logic [FRAMES_W-1:0] FRAMES_TIER1 = 24'd100;
  localparam logic [FRAMES_W-1:0] FRAMES_TIER2 = 24'd1000;
  localparam logic [FRAMES_W-1:0] FRAMES_MAX   = 24'hFFFFFF;

  localparam int unsigned FREQ_ENTRIES = 51;

  localparam logic [CHAN_W-1:0] CHAN_TABLE [FREQ_ENTRIES] = '{
    8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd13,
    8'd14, 8'd32, 8'd36, 8'd40, 8'd44, 8'd48, 8'd52, 8'd56, 8'd60, 8'd64, 8'd68,
    8'd72, 8'd76, 8'd80, 8'd84, 8'd88, 8'd92, 8'd96, 8'd100, 8'd104, 8'd108,
    8'd112, 8'd116, 8'd120, 8'd124, 8'd128, 8'd132, 8'd136, 8'd140, 8'd144,
    8'd149, 8'd153, 8'd157, 8'd161, 8'd165, 8'd169, 8'd173, 8'd177
  };

  localparam logic [FREQ_W-1:0] MHZ_TABLE [FREQ_ENTRIES] = '{
    16'd2412, 16'd2417, 16'd2422, 16'd2427, 16'd2432, 16'd2437, 16'd2442,
    16'd2447, 16'd2452, 16'd2457, 16'd2462, 16'd2467, 16'd2472, 16'd2484,
    16'd5160, 16'd5180, 16'd5200, 16'd5220, 16'd5240, 16'd5260, 16'd5280,
    16'd5300, 16'd5320, 16'd5340, 16'd5360, 16'd5380, 16'd5400, 16'd5420,
    16'd5440, 16'd5460, 16'd5480, 16'd5500, 16'd5520, 16'd5540, 16'd5560,
    16'd5580, 16'd5600, 16'd5620, 16'd5640, 16'd5660, 16'd5680, 16'd5700,
    16'd5720, 16'd5745, 16'd5765, 16'd5785, 16'd5805, 16'd5825, 16'd5845,
    16'd5865, 16'd5885
  };

  typedef struct packed {
    logic                req_type;
    logic [ADDR_W-1:0]   tx_addr;
    logic [FREQ_W-1:0]   freq_mhz;
    logic [TIME_W-1:0]   now_seconds;
    logic [RIDX_W-1:0]   read_index;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [RIDX_W-1:0]    entry_index;
    logic                 entry_valid;
    logic [ADDR_W-1:0]    entry_addr;
    logic [FRAMES_W-1:0]  frame_count;
    logic [CHAN_W-1:0]    channel_number;
    logic [CNT_OUT_W-1:0] live_count;
    logic [CNT_OUT_W-1:0] evicted_count;
  } rsp_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   addr;
    logic [FRAMES_W-1:0] frames;
    logic [CHAN_W-1:0]   chan;
    logic [TIME_W-1:0]   last_seen;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic read_issue;
    logic read_capture;
    logic scan_en;
    logic update;
    logic age_en;
    logic load_rsp;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_busy;
    logic aging_on;
  } sts_t;

  // unlisted frequencies give channel 0
  function automatic logic [CHAN_W-1:0] chan_lookup(logic [FREQ_W-1:0] mhz);
    logic [CHAN_W-1:0] ch;
    ch = '0;
    for (int i = 0; i < FREQ_ENTRIES; i++) begin
      if (mhz == MHZ_TABLE[i]) ch = ch | CHAN_TABLE[i];
    end
    return ch;
  endfunction

endpackage

// ----- sv/stt_if.sv -----
// request, response and configuration channel interfaces of the station table
interface stt_req_if import stt_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface stt_rsp_if import stt_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface stt_cfg_if import stt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- sv/stt_ctrl.sv -----
// sequencing state machine of the station table
module stt_ctrl import stt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  input  logic req_is_read_i,
  output logic req_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_ISSUE,
    S_RD_DATA,
    S_SCAN,
    S_UPDATE,
    S_AGE,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = req_is_read_i ? S_RD_ISSUE : S_SCAN;
        end
      end
      S_RD_ISSUE: begin
        cmd_o.read_issue = 1'b1;
        state_d          = S_RD_DATA;
      end
      S_RD_DATA: begin
        cmd_o.read_capture = 1'b1;
        state_d            = S_FINISH;
      end
      S_SCAN: begin
        cmd_o.scan_en = 1'b1;
        if (sts_i.scan_done) state_d = S_UPDATE;
      end
      S_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = sts_i.aging_on ? S_AGE : S_FINISH;
      end
      S_AGE: begin
        cmd_o.age_en = 1'b1;
        if (sts_i.scan_done) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!sts_i.out_busy) begin
          cmd_o.load_rsp = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign req_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/stt_datapath.sv -----
// slot memory, valid bits, scan pointer, counters and result register
module stt_datapath import stt_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  req_t                 req_payload_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  output rsp_t                 rsp_o,
  output logic                 rsp_valid_o,
  input  logic                 rsp_ready_i
);

  localparam int unsigned IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);

  function automatic logic too_idle(logic [FRAMES_W-1:0] frames, logic [TIME_W-1:0] age);
    logic r;
    if (age <= AGE_KEEP)            r = 1'b0;
    else if (frames <= FRAMES_TIER0) r = 1'b1;
    else if (frames <= FRAMES_TIER1) r = (age >= AGE_TIER1);
    else if (frames <= FRAMES_TIER2) r = (age >= AGE_TIER2);
    else                             r = (age >= AGE_TIER3);
    return r;
  endfunction

  function automatic logic [CNT_OUT_W-1:0] sat_cnt(logic [CW-1:0] v);
    return (32'(v) > 32'(CNT_OUT_MAX)) ? CNT_OUT_MAX : CNT_OUT_W'(v);
  endfunction

  logic [5:0]             entries_q;
  logic                   aging_q;
  logic [TABLE_SLOTS-1:0] valid_q, valid_d;
  entry_t                 mem_q [TABLE_SLOTS];
  entry_t                 rd_data_q;
  logic [IW-1:0]          rd_addr;
  logic                   mem_we;
  logic [IW-1:0]          wr_idx;
  entry_t                 wr_data;
  req_t                   item_q;
  logic [CHAN_W-1:0]      chan_q;
  logic [CW-1:0]          limit;
  logic [CW-1:0]          ptr_q, ptr_d;
  logic                   pipe_vld_q;
  logic [IW-1:0]          pipe_idx_q;
  logic                   found_q, free_q;
  logic [IW-1:0]          hit_idx_q, free_idx_q;
  logic [FRAMES_W-1:0]    hit_frames_q;
  logic [CW-1:0]          live_q, live_d;
  logic [CW-1:0]          evicted_q;
  status_e                res_status_q;
  logic [RIDX_W-1:0]      res_idx_q;
  logic                   res_live_q;
  entry_t                 res_entry_q;
  rsp_t                   rsp_q;
  logic                   rsp_valid_q;
  logic                   issue;
  logic                   ridx_ok;
  logic                   addr_match;
  logic                   evict;
  logic                   scan_eval;
  logic                   age_eval;
  logic [TIME_W-1:0]      age;

  assign limit = (32'(entries_q) > TABLE_SLOTS) ? CW'(TABLE_SLOTS) : CW'(entries_q);

  assign issue   = (cmd_i.scan_en || cmd_i.age_en) && (ptr_q < limit);
  assign rd_addr = cmd_i.read_issue ? IW'(item_q.read_index) : ptr_q[IW-1:0];
  assign ridx_ok = (32'(item_q.read_index) < TABLE_SLOTS);

  assign addr_match = valid_q[pipe_idx_q] && (rd_data_q.addr == item_q.tx_addr);
  assign age        = item_q.now_seconds - rd_data_q.last_seen;
  assign evict      = valid_q[pipe_idx_q] && too_idle(rd_data_q.frames, age);
  assign scan_eval  = cmd_i.scan_en && pipe_vld_q;
  assign age_eval   = cmd_i.age_en && pipe_vld_q;

  // the observed slot: refresh on a hit, fresh entry in the first free slot otherwise
  assign mem_we = cmd_i.update && (found_q || free_q);
  assign wr_idx = found_q ? hit_idx_q : free_idx_q;
  always_comb begin
    wr_data.addr      = item_q.tx_addr;
    wr_data.chan      = chan_q;
    wr_data.last_seen = item_q.now_seconds;
    if (found_q) begin
      wr_data.frames = (hit_frames_q == FRAMES_MAX) ? hit_frames_q
                                                    : hit_frames_q + FRAMES_W'(1);
    end else begin
      wr_data.frames = FRAMES_W'(1);
    end
  end

  always_comb begin
    valid_d = valid_q;
    live_d  = live_q;
    if (mem_we) begin
      valid_d[wr_idx] = 1'b1;
      if (!found_q) live_d = live_q + CW'(1);
    end
    if (age_eval && evict) begin
      valid_d[pipe_idx_q] = 1'b0;
      if (live_q != '0) live_d = live_q - CW'(1);
    end
  end

  always_comb begin
    ptr_d = ptr_q;
    if (cmd_i.start || cmd_i.update) ptr_d = '0;
    else if (issue)                  ptr_d = ptr_q + CW'(1);
  end

  // slot memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wr_idx] <= wr_data;
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q   <= ENTRIES_RESET;
      aging_q     <= AGING_RESET;
      valid_q     <= '0;
      live_q      <= '0;
      ptr_q       <= '0;
      pipe_vld_q  <= 1'b0;
      found_q     <= 1'b0;
      free_q      <= 1'b0;
      evicted_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_ENTRIES_IN_USE) entries_q <= cfg_data_i[5:0];
      if (cfg_we_i && cfg_index_i == CFG_AGING_ENABLE)   aging_q   <= cfg_data_i[0];
      valid_q    <= valid_d;
      live_q     <= live_d;
      ptr_q      <= ptr_d;
      pipe_vld_q <= issue;
      if (cmd_i.start) begin
        found_q   <= 1'b0;
        free_q    <= 1'b0;
        evicted_q <= '0;
      end else begin
        if (scan_eval && addr_match)        found_q   <= 1'b1;
        if (scan_eval && !valid_q[pipe_idx_q]) free_q <= 1'b1;
        if (age_eval && evict)              evicted_q <= evicted_q + CW'(1);
      end
      if (cmd_i.load_rsp)   rsp_valid_q <= 1'b1;
      else if (rsp_ready_i) rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      item_q <= req_payload_i;
      chan_q <= chan_lookup(req_payload_i.freq_mhz);
    end
    if (issue) pipe_idx_q <= ptr_q[IW-1:0];
    // first hit and first free slot win
    if (scan_eval && addr_match && !found_q) begin
      hit_idx_q    <= pipe_idx_q;
      hit_frames_q <= rd_data_q.frames;
    end
    if (scan_eval && !valid_q[pipe_idx_q] && !free_q) free_idx_q <= pipe_idx_q;
    if (cmd_i.read_capture) begin
      res_status_q <= ST_READ;
      res_idx_q    <= item_q.read_index;
      res_live_q   <= ridx_ok && valid_q[IW'(item_q.read_index)];
      res_entry_q  <= rd_data_q;
    end
    if (cmd_i.update) begin
      res_status_q <= found_q ? ST_UPDATED : (free_q ? ST_INSERTED : ST_DROPPED);
      res_idx_q    <= (found_q || free_q) ? RIDX_W'(wr_idx) : '0;
      res_live_q   <= found_q || free_q;
      res_entry_q  <= wr_data;
    end
    if (cmd_i.load_rsp) begin
      rsp_q.status         <= res_status_q;
      rsp_q.entry_index    <= res_idx_q;
      rsp_q.entry_valid    <= res_live_q;
      rsp_q.entry_addr     <= res_live_q ? res_entry_q.addr : '0;
      rsp_q.frame_count    <= res_live_q ? res_entry_q.frames : '0;
      rsp_q.channel_number <= res_live_q ? res_entry_q.chan : '0;
      rsp_q.live_count     <= sat_cnt(live_q);
      rsp_q.evicted_count  <= sat_cnt(evicted_q);
    end
  end

  assign sts_o.scan_done = (ptr_q == limit) && !pipe_vld_q;
  assign sts_o.out_busy  = rsp_valid_q && !rsp_ready_i;
  assign sts_o.aging_on  = aging_q;

  assign rsp_o       = rsp_q;
  assign rsp_valid_o = rsp_valid_q;

`ifndef SYNTHESIS
  a_live_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(live_q) == $countones(valid_q))
    else $error("live count differs from number of valid slots");

  a_written_slot_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> valid_q[$past(wr_idx)])
    else $error("slot written by an observe is not valid");

  a_scan_within_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pipe_vld_q |-> (32'(pipe_idx_q) < 32'(limit)))
    else $error("scan touched a slot beyond the slots in use");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_rsp |-> !(rsp_valid_q && !rsp_ready_i))
    else $error("result overwritten before its transfer");
`endif

endmodule

// ----- sv/station_table_with_tiered_aging_top.sv -----
// top level of the station table with tiered aging
// Station table with tiered aging: keeps up to TABLE_SLOTS transmitter
// addresses with a saturating frame count, a channel and a last-seen time.
// An observe request looks up its address among the first entries_in_use
// slots, refreshes a hit or fills the first free slot (dropped when none is
// free), then, with aging_enable set, evicts entries idle longer than their
// count tier allows. A read request reports one slot. One request is worked
// at a time, and every request gives exactly one response. A read request
// issues its slot address to the registered read port, captures the data
// and then loads the response. The slot memory has a single read port, so
// the lookup pass and then the aging pass step through one slot per cycle;
// an observe writes the observed slot after the lookup pass, then runs the
// aging pass when aging_enable is set, and then loads the response. A
// response is loaded only when the output register is free. A finished
// response waits in an output register, so the next request can be taken
// before it is transferred. The table is empty right after reset, no
// clearing pass needed; configuration writes are always taken and
// should be made between requests.
module station_table_with_tiered_aging_top import stt_pkg::*; #(
  parameter int unsigned TABLE_SLOTS = 32
) (
  input logic    clk_i,
  input logic    rst_ni,
  stt_req_if.sink   req_i,
  stt_rsp_if.source rsp_o,
  stt_cfg_if.sink   cfg_i
);

  cmd_t cmd;
  sts_t sts;

  // configuration writes need no back-pressure
  assign cfg_i.ready = 1'b1;

  stt_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_valid_i   (req_i.valid),
    .req_is_read_i (req_i.payload.req_type == REQ_READ),
    .req_ready_o   (req_i.ready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  stt_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_payload_i (req_i.payload),
    .cfg_we_i      (cfg_i.valid),
    .cfg_index_i   (cfg_i.index),
    .cfg_data_i    (cfg_i.data),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .rsp_o         (rsp_o.payload),
    .rsp_valid_o   (rsp_o.valid),
    .rsp_ready_i   (rsp_o.ready)
  );

endmodule
